// ----- sv/lpht_pkg.sv -----
package lpht_pkg;

   localparam int TABLE_SLOTS   = 256;
   localparam int KEY_MAX_BYTES = 8;
   localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
   localparam int KEY_W         = 64;
   localparam int KLEN_W        = 4;
   localparam int VAL_W         = 32;
   localparam int CNT_W         = 9;
   localparam int HASH_W        = 64;
   localparam int BYTE_CNT_W    = 4;
   // key, key length, value
   localparam int ENTRY_W       = KEY_W + KLEN_W + VAL_W;

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [HASH_W-1:0] FNV_MULT  = 64'h00000100000001b3;

   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_FOUND  = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_LIVE    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   localparam logic [CNT_W-1:0] LOAD_LIMIT_RESET = 9'd192;

   typedef struct packed {
      logic hash_start;   // load key and start hashing
      logic hash_step;    // absorb one byte (xor + multiply)
      logic probe_start;  // set probe index from hash
      logic examine;      // evaluate read data
      logic advance;      // step probe index
      logic commit;       // do the write and build result
      logic clear_step;   // clear one mark after reset
   } lpht_cmd_type;

   typedef struct packed {
      logic hash_done;
      logic probe_stop;   // empty met, hit, or sweep finished
      logic clear_done;
   } lpht_stat_type;

endpackage

// ----- sv/lpht_if.sv -----
interface lpht_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [lpht_pkg::KEY_W-1:0]   key_bytes;
   logic [lpht_pkg::KLEN_W-1:0]  key_length;
   logic [lpht_pkg::VAL_W-1:0]   new_value;
   modport source (output valid, opcode, key_bytes, key_length, new_value, input ready);
   modport sink (input valid, opcode, key_bytes, key_length, new_value, output ready);
endinterface

interface lpht_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [lpht_pkg::VAL_W-1:0]  read_value;
   logic [lpht_pkg::CNT_W-1:0]  entry_count;
   modport source (output valid, status, read_value, entry_count, input ready);
   modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

interface lpht_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lpht_pkg::CNT_W-1:0]  load_limit;
   modport source (output valid, load_limit, input ready);
   modport sink (input valid, load_limit, output ready);
endinterface

// ----- sv/lpht_ram.sv -----
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- sv/lpht_datapath.sv -----
module lpht_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lpht_pkg::lpht_cmd_type        cmd,
   output lpht_pkg::lpht_stat_type       stat,
   input  logic [1:0]                    req_opcode,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key_bytes,
   input  logic [lpht_pkg::KLEN_W-1:0]   req_key_length,
   input  logic [lpht_pkg::VAL_W-1:0]    req_new_value,
   input  logic [lpht_pkg::CNT_W-1:0]    load_limit,
   output logic [1:0]                    res_status,
   output logic [lpht_pkg::VAL_W-1:0]    res_read_value,
   output logic [lpht_pkg::CNT_W-1:0]    res_entry_count
);
   localparam int SB = lpht_pkg::SLOT_BITS;

   logic [1:0]                     op_ff;
   logic [lpht_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lpht_pkg::KLEN_W-1:0]    len_ff, len_in;
   logic [lpht_pkg::VAL_W-1:0]     val_ff;
   logic [lpht_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic [lpht_pkg::HASH_W-1:0]    mix;
   logic [lpht_pkg::BYTE_CNT_W-1:0] byte_ff;
   logic [SB-1:0]                  idx_ff;
   logic [SB:0]                    probes_ff;
   logic                           hit_ff, have_free_ff;
   logic [SB-1:0]                  found_ff, free_ff;
   logic [lpht_pkg::CNT_W-1:0]     count_ff;
   logic [SB-1:0]                  clr_ff;
   logic                           clr_done_ff;

   logic                           ent_we;
   logic [SB-1:0]                  ent_wa;
   logic [lpht_pkg::ENTRY_W-1:0]   ent_wd, ent_rd;
   logic                           mark_we;
   logic [SB-1:0]                  mark_wa;
   logic [1:0]                     mark_wd, mark_rd;
   logic [lpht_pkg::KEY_W-1:0]     rd_key;
   logic [lpht_pkg::KLEN_W-1:0]    rd_len;
   logic [lpht_pkg::VAL_W-1:0]     rd_val;
   logic                           key_match;
   logic [7:0]                     cur_byte;
   logic                           insert_ok;

   lpht_ram #(.WIDTH(lpht_pkg::ENTRY_W), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (idx_ff),
      .rd_data (ent_rd)
   );

   lpht_ram #(.WIDTH(2), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (idx_ff),
      .rd_data (mark_rd)
   );

   assign rd_key = ent_rd[lpht_pkg::ENTRY_W-1 -: lpht_pkg::KEY_W];
   assign rd_len = ent_rd[lpht_pkg::VAL_W +: lpht_pkg::KLEN_W];
   assign rd_val = ent_rd[lpht_pkg::VAL_W-1:0];
   assign key_match = (rd_len == len_ff) && (rd_key == key_ff);

   // saturate length and mask bytes beyond it
   always_comb begin
      len_in = (req_key_length > lpht_pkg::KLEN_W'(lpht_pkg::KEY_MAX_BYTES))
             ? lpht_pkg::KLEN_W'(lpht_pkg::KEY_MAX_BYTES) : req_key_length;
      for (int i = 0; i < lpht_pkg::KEY_W / 8; i++) begin
         key_in[8*i +: 8] = (i < int'(len_in)) ? req_key_bytes[8*i +: 8] : 8'd0;
      end
   end

   // multiply by 2^40 + 0x1b3 as a sum of shifts
   assign cur_byte = key_ff[8*byte_ff[2:0] +: 8];
   assign mix      = hash_ff ^ {56'd0, cur_byte};
   assign hash_in  = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5)
                   + (mix << 4) + (mix << 1) + mix;

   always_comb begin
      stat.hash_done  = (byte_ff == len_ff);
      stat.clear_done = clr_done_ff;
      stat.probe_stop = (mark_rd == lpht_pkg::MARK_EMPTY) ||
                        (mark_rd == lpht_pkg::MARK_LIVE && key_match) ||
                        (probes_ff == (SB+1)'(lpht_pkg::TABLE_SLOTS - 1));
   end

   assign insert_ok = !hit_ff && have_free_ff && (count_ff < load_limit);

   always_comb begin
      ent_we = 1'b0;
      ent_wa = hit_ff ? found_ff : free_ff;
      ent_wd = {key_ff, len_ff, val_ff};
      if (cmd.commit && op_ff == lpht_pkg::OP_SET && (hit_ff || insert_ok)) begin
         ent_we = 1'b1;
      end
      if (hit_ff) ent_wd = {rd_key, rd_len, val_ff};
   end

   always_comb begin
      mark_we = 1'b0;
      mark_wa = clr_ff;
      mark_wd = lpht_pkg::MARK_EMPTY;
      if (cmd.clear_step) begin
         mark_we = 1'b1;
      end else if (cmd.commit && op_ff == lpht_pkg::OP_SET && insert_ok) begin
         mark_we = 1'b1;
         mark_wa = free_ff;
         mark_wd = lpht_pkg::MARK_LIVE;
      end else if (cmd.commit && op_ff == lpht_pkg::OP_DELETE && hit_ff) begin
         mark_we = 1'b1;
         mark_wa = found_ff;
         mark_wd = lpht_pkg::MARK_DELETED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         hit_ff      <= 1'b0;
         have_free_ff <= 1'b0;
         probes_ff   <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == SB'(lpht_pkg::TABLE_SLOTS - 1)) clr_done_ff <= 1'b1;
         end
         if (cmd.hash_start) begin
            op_ff   <= req_opcode;
            key_ff  <= key_in;
            len_ff  <= len_in;
            val_ff  <= req_new_value;
            hash_ff <= lpht_pkg::FNV_BASIS;
            byte_ff <= '0;
         end
         if (cmd.hash_step) begin
            hash_ff <= hash_in;
            byte_ff <= byte_ff + 1'b1;
         end
         if (cmd.probe_start) begin
            idx_ff       <= hash_ff[SB-1:0];
            probes_ff    <= '0;
            hit_ff       <= 1'b0;
            have_free_ff <= 1'b0;
         end
         if (cmd.examine) begin
            if (mark_rd == lpht_pkg::MARK_LIVE) begin
               if (key_match) begin
                  hit_ff   <= 1'b1;
                  found_ff <= idx_ff;
               end
            end else if (!have_free_ff) begin
               have_free_ff <= 1'b1;
               free_ff      <= idx_ff;
            end
         end
         if (cmd.advance) begin
            idx_ff    <= idx_ff + 1'b1;
            probes_ff <= probes_ff + 1'b1;
         end
         if (cmd.commit) begin
            res_status      <= lpht_pkg::ST_ABSENT;
            res_read_value  <= '0;
            res_entry_count <= count_ff;
            unique case (op_ff)
               lpht_pkg::OP_GET: begin
                  if (hit_ff) begin
                     res_status     <= lpht_pkg::ST_FOUND;
                     res_read_value <= rd_val;
                  end
               end
               lpht_pkg::OP_SET: begin
                  if (hit_ff) begin
                     res_status <= lpht_pkg::ST_FOUND;
                  end else if (insert_ok) begin
                     count_ff         <= count_ff + 1'b1;
                     res_entry_count  <= count_ff + 1'b1;
                     res_status       <= lpht_pkg::ST_INSERT;
                  end else begin
                     res_status <= lpht_pkg::ST_FULL;
                  end
               end
               lpht_pkg::OP_DELETE: begin
                  if (hit_ff) begin
                     count_ff          <= count_ff - 1'b1;
                     res_entry_count   <= count_ff - 1'b1;
                     res_status        <= lpht_pkg::ST_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end
endmodule

// ----- sv/lpht_ctrl.sv -----
module lpht_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lpht_pkg::lpht_cmd_type   cmd,
   input  lpht_pkg::lpht_stat_type  stat
);
   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_HASH    = 8'b0000_0100,
      S_READ    = 8'b0000_1000,
      S_WAIT    = 8'b0001_0000,
      S_EXAMINE = 8'b0010_0000,
      S_COMMIT  = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      skip_ff, skip_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      skip_in      = skip_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               cmd.clear_step = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.hash_start = 1'b1;
               // unused opcode: no probe, absent result
               skip_in  = (req_opcode == lpht_pkg::OP_UNUSED);
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (skip_ff) begin
               state_in = S_COMMIT;
            end else if (stat.hash_done) begin
               cmd.probe_start = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_EXAMINE;
         end
         S_EXAMINE: begin
            cmd.examine = 1'b1;
            if (stat.probe_stop) begin
               state_in = S_COMMIT;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
         end
         S_COMMIT: begin
            // hold until the previous result has left
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         skip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         skip_ff      <= skip_in;
      end
   end
endmodule

// ----- sv/linear_probe_hash_table.sv -----
// Each accepted item is hashed one key byte per cycle, then probed slot by slot
// through the registered memories (S_READ, S_WAIT, S_EXAMINE) before its result
// is committed; the unused opcode skips hashing and probing.
// Only one item is handled at a time; an item may be taken while the last
// result waits. Reset: synchronous; a clearing pass empties all slot marks,
// during which no item is taken. load_limit resets to 192.
module linear_probe_hash_table (
   input logic        clock,
   input logic        reset,
   lpht_req_if.sink   req,
   lpht_rsp_if.source rsp,
   lpht_csr_if.sink   csr
);
   lpht_pkg::lpht_cmd_type  cmd;
   lpht_pkg::lpht_stat_type stat;
   logic [lpht_pkg::CNT_W-1:0] load_limit_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= lpht_pkg::LOAD_LIMIT_RESET;
      end else if (csr.valid) begin
         load_limit_ff <= csr.load_limit;
      end
   end

   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_opcode (req.opcode),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   lpht_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req.opcode),
      .req_key_bytes   (req.key_bytes),
      .req_key_length  (req.key_length),
      .req_new_value   (req.new_value),
      .load_limit      (load_limit_ff),
      .res_status      (rsp.status),
      .res_read_value  (rsp.read_value),
      .res_entry_count (rsp.entry_count)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("item accepted while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.entry_count <= lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS)))
      else $error("entry count out of range");

   a_get_value: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != lpht_pkg::ST_FOUND) |-> (rsp.read_value == '0))
      else $error("read value not zero");
endmodule
